// ===== rtl/core/srs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants of the similarity registration solver
// Pixel and result formats, the frame record that moves from the accumulator
// to the solver, permutation tables for the determinant expansion and helpers.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int COORD_BITS  = 12;
  localparam int SAMPLE_BITS = 16;

  // Front-end arithmetic widths. The sum of two coordinate by gradient
  // products reaches +2^(XG_W-1) when all four inputs sit at their minimum.
  localparam int XG_W     = COORD_BITS + SAMPLE_BITS;
  localparam int F_W      = XG_W + 2;
  localparam int ND_W     = SAMPLE_BITS + 1;
  localparam int NPROD_W  = 2 * F_W;
  localparam int PSAT_W   = (NPROD_W > 65) ? NPROD_W : 65;

  localparam int ACC_W    = 64;
  localparam int N_NORM   = 10;
  localparam int N_RHS    = 4;

  // Frame queue between the accumulator and the solver.
  localparam int QDEPTH   = 2;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int QPTR_W   = $clog2(QDEPTH);

  // Solver widths: a 4x4 determinant of 64-bit entries needs 4*64 bits plus
  // a few bits of growth for the 24 products.
  localparam int DET_W     = 4 * ACC_W + 8;
  localparam int DIV_W     = DET_W + 40;
  localparam int QUO_W     = 34;
  localparam int RES_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int N_PERM    = 24;
  localparam int PIDX_W    = 5;
  localparam int MCNT_W    = 6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  col_coord;
    logic signed [COORD_BITS-1:0]  row_coord;
    logic signed [SAMPLE_BITS-1:0] grad_x;
    logic signed [SAMPLE_BITS-1:0] grad_y;
    logic signed [SAMPLE_BITS-1:0] intensity_diff;
    logic                          last_pixel;
  } in_pkt_t;

  typedef struct packed {
    logic signed [RES_W-1:0] scale_term;
    logic signed [RES_W-1:0] rotation_term;
    logic signed [RES_W-1:0] shift_x;
    logic signed [RES_W-1:0] shift_y;
    logic                    singular;
  } out_pkt_t;

  typedef struct packed {
    logic [N_NORM-1:0][ACC_W-1:0] normal_sums;
    logic [N_RHS-1:0][ACC_W-1:0]  rhs_sums;
  } frame_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } srs_state_t;

  // Factor pairs (i, j), i <= j, in the order the normal sums are kept.
  localparam logic [1:0] NORM_I [N_NORM] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                             2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam logic [1:0] NORM_J [N_NORM] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                             2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // Permutations of four columns, packed {p3, p2, p1, p0}. The first 1, 2, 6
  // and 24 entries are exactly the permutations of the leading 1, 2, 3 and 4
  // columns, so one table serves every leading minor.
  localparam logic [7:0] PERM_TBL [N_PERM] = '{
    8'b11_10_01_00, 8'b11_10_00_01, 8'b11_00_10_01, 8'b11_01_00_10,
    8'b11_01_10_00, 8'b11_00_01_10, 8'b00_11_10_01, 8'b00_10_11_01,
    8'b00_11_01_10, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_01_10_11,
    8'b01_11_10_00, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_00_11_10,
    8'b01_10_00_11, 8'b01_00_10_11, 8'b10_11_01_00, 8'b10_01_11_00,
    8'b10_11_00_01, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_00_01_11
  };

  function automatic logic perm_odd(input logic [7:0] p);
    logic odd;
    odd = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (p[2*i +: 2] > p[2*j +: 2]) begin
          odd = ~odd;
        end
      end
    end
    return odd;
  endfunction

  // Index of the last permutation for a minor of order ord + 1.
  function automatic logic [PIDX_W-1:0] term_last(input logic [1:0] ord);
    logic [PIDX_W-1:0] t;
    case (ord)
      2'd0:    t = PIDX_W'(0);
      2'd1:    t = PIDX_W'(1);
      2'd2:    t = PIDX_W'(5);
      default: t = PIDX_W'(N_PERM - 1);
    endcase
    return t;
  endfunction

  // Position of entry (r, c) of the symmetric matrix in the normal sums.
  function automatic logic [3:0] sym_idx(input logic [1:0] r, input logic [1:0] c);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [3:0] s;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    case ({lo, hi})
      4'b00_00: s = 4'd0;
      4'b00_01: s = 4'd1;
      4'b00_10: s = 4'd2;
      4'b00_11: s = 4'd3;
      4'b01_01: s = 4'd4;
      4'b01_10: s = 4'd5;
      4'b01_11: s = 4'd6;
      4'b10_10: s = 4'd7;
      4'b10_11: s = 4'd8;
      4'b11_11: s = 4'd9;
      default:  s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [ACC_W-1:0] sat_prod(input logic signed [PSAT_W-1:0] v);
    logic [ACC_W-1:0] s;
    if ((&v[PSAT_W-1:ACC_W-1]) || !(|v[PSAT_W-1:ACC_W-1])) begin
      s = v[ACC_W-1:0];
    end else if (v[PSAT_W-1]) begin
      s = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      s = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0]   w;
    logic [ACC_W-1:0] s;
    w = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (w[ACC_W] != w[ACC_W-1]) begin
      s = w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      s = w[ACC_W-1:0];
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/srs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_front: pixel pipeline and normal equation accumulators
// Forms the four factors of each pixel, their pairwise products and the
// right-hand products, and adds them into saturating 64-bit sums. A frame's
// sums are pushed to the frame queue on the last pixel and then cleared.
// ----------------------------------------------------------------------------
module srs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srs_pkg::in_pkt_t in_data,
  input  srs_pkg::qstat_t  qstat,
  output logic             push_valid,
  output srs_pkg::frame_t  push_data
);

  // Stage 1: registered sample.
  logic                                   v1_r;
  srs_pkg::in_pkt_t                       s1_r;
  // Stage 2: coordinate by gradient products.
  logic                                   v2_r;
  logic                                   last2_r;
  logic signed [srs_pkg::XG_W-1:0]        xgx2_r, ygy2_r, ygx2_r, xgy2_r;
  logic signed [srs_pkg::SAMPLE_BITS-1:0] gx2_r, gy2_r, d2_r;
  // Stage 3: factors p, q, gx, gy and the negated difference.
  logic                                   v3_r;
  logic                                   last3_r;
  logic signed [srs_pkg::F_W-1:0]         f3_r [4];
  logic signed [srs_pkg::ND_W-1:0]        negd3_r;
  // Stage 4: saturated products.
  logic                                   v4_r;
  logic                                   last4_r;
  logic [srs_pkg::ACC_W-1:0]              nprod4_r [srs_pkg::N_NORM];
  logic [srs_pkg::ACC_W-1:0]              rprod4_r [srs_pkg::N_RHS];
  // Stage 5: running sums.
  logic [srs_pkg::ACC_W-1:0]              norm_r   [srs_pkg::N_NORM];
  logic [srs_pkg::ACC_W-1:0]              norm_nxt [srs_pkg::N_NORM];
  logic [srs_pkg::ACC_W-1:0]              rhs_r    [srs_pkg::N_RHS];
  logic [srs_pkg::ACC_W-1:0]              rhs_nxt  [srs_pkg::N_RHS];

  logic signed [srs_pkg::NPROD_W-1:0]     nprod [srs_pkg::N_NORM];
  logic signed [srs_pkg::NPROD_W-1:0]     rprod [srs_pkg::N_RHS];
  logic [srs_pkg::ACC_W-1:0]              nsum  [srs_pkg::N_NORM];
  logic [srs_pkg::ACC_W-1:0]              rsum  [srs_pkg::N_RHS];
  logic [2:0]                             pending;
  logic                                   accept;

  // Every last pixel in flight will need a queue slot, so count them with
  // the frames already queued.
  always_comb begin
    pending = 3'(qstat.count) + 3'(v1_r & s1_r.last_pixel) + 3'(v2_r & last2_r)
              + 3'(v3_r & last3_r) + 3'(v4_r & last4_r);
    in_ready = (pending < 3'(srs_pkg::QDEPTH));
    accept = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    for (int n = 0; n < srs_pkg::N_NORM; n++) begin
      nprod[n] = f3_r[srs_pkg::NORM_I[n]] * f3_r[srs_pkg::NORM_J[n]];
    end
    for (int i = 0; i < srs_pkg::N_RHS; i++) begin
      rprod[i] = negd3_r * f3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    last2_r <= s1_r.last_pixel;
    xgx2_r  <= s1_r.col_coord * s1_r.grad_x;
    ygy2_r  <= s1_r.row_coord * s1_r.grad_y;
    ygx2_r  <= s1_r.row_coord * s1_r.grad_x;
    xgy2_r  <= s1_r.col_coord * s1_r.grad_y;
    gx2_r   <= s1_r.grad_x;
    gy2_r   <= s1_r.grad_y;
    d2_r    <= s1_r.intensity_diff;

    last3_r <= last2_r;
    f3_r[0] <= srs_pkg::F_W'(xgx2_r) + srs_pkg::F_W'(ygy2_r);
    f3_r[1] <= srs_pkg::F_W'(ygx2_r) - srs_pkg::F_W'(xgy2_r);
    f3_r[2] <= srs_pkg::F_W'(gx2_r);
    f3_r[3] <= srs_pkg::F_W'(gy2_r);
    negd3_r <= -srs_pkg::ND_W'(d2_r);

    last4_r <= last3_r;
    for (int n = 0; n < srs_pkg::N_NORM; n++) begin
      nprod4_r[n] <= srs_pkg::sat_prod(srs_pkg::PSAT_W'(nprod[n]));
    end
    for (int i = 0; i < srs_pkg::N_RHS; i++) begin
      rprod4_r[i] <= srs_pkg::sat_prod(srs_pkg::PSAT_W'(rprod[i]));
    end
  end

  always_comb begin
    push_valid = v4_r && last4_r;
    for (int n = 0; n < srs_pkg::N_NORM; n++) begin
      nsum[n] = v4_r ? srs_pkg::sat_add(norm_r[n], nprod4_r[n]) : norm_r[n];
      push_data.normal_sums[n] = nsum[n];
      norm_nxt[n] = push_valid ? '0 : nsum[n];
    end
    for (int i = 0; i < srs_pkg::N_RHS; i++) begin
      rsum[i] = v4_r ? srs_pkg::sat_add(rhs_r[i], rprod4_r[i]) : rhs_r[i];
      push_data.rhs_sums[i] = rsum[i];
      rhs_nxt[i] = push_valid ? '0 : rsum[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < srs_pkg::N_NORM; n++) begin
        norm_r[n] <= '0;
      end
      for (int i = 0; i < srs_pkg::N_RHS; i++) begin
        rhs_r[i] <= '0;
      end
    end else begin
      norm_r <= norm_nxt;
      rhs_r  <= rhs_nxt;
    end
  end

endmodule

// ===== rtl/core/srs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_queue: frame queue
// Holds the finished sums of whole frames until the solver takes them.
// ----------------------------------------------------------------------------
module srs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  srs_pkg::frame_t push_data,
  input  logic            pop,
  output logic            head_valid,
  output srs_pkg::frame_t head_data,
  output srs_pkg::qstat_t qstat
);

  srs_pkg::frame_t                entry_r [srs_pkg::QDEPTH];
  logic [srs_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [srs_pkg::QCNT_W-1:0]     count_r;

  always_comb begin
    head_valid  = (count_r != '0);
    head_data   = entry_r[rd_ptr_r];
    qstat.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + srs_pkg::QCNT_W'(push_valid) - srs_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/srs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_back: exact solver of the 4x4 normal equations
// Expands each determinant over the permutation table with a bit-serial
// multiplier, checks the leading minors, forms every unknown by Cramer's rule
// and a restoring divider, and holds the result in an output register.
// ----------------------------------------------------------------------------
module srs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  srs_pkg::frame_t   head_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output srs_pkg::out_pkt_t out_data
);

  localparam logic signed [srs_pkg::RES_W-1:0] RES_MAX = {1'b0, {(srs_pkg::RES_W-1){1'b1}}};
  localparam logic signed [srs_pkg::RES_W-1:0] RES_MIN = {1'b1, {(srs_pkg::RES_W-1){1'b0}}};
  localparam logic signed [srs_pkg::RES_W:0]   ONE_Q   = (srs_pkg::RES_W+1)'(1) << srs_pkg::FRAC_BITS;

  srs_pkg::srs_state_t            state_r, state_nxt;
  logic                           num_phase_r;
  logic [1:0]                     ord_r, row_r, col_r;
  logic [srs_pkg::PIDX_W-1:0]     idx_r;
  logic                           neg_r;
  logic [srs_pkg::MCNT_W-1:0]     cnt_r;
  logic [srs_pkg::ACC_W-1:0]      mag_r;
  logic [srs_pkg::DET_W-1:0]      acc_r, prod_r, base_r, den_r;
  logic [srs_pkg::DIV_W-1:0]      rem_r, dv_r;
  logic [srs_pkg::QUO_W-1:0]      quo_r;
  logic                           qneg_r;
  logic                           sing_r;
  logic signed [srs_pkg::RES_W-1:0] k_r [4];
  logic                           out_valid_r;
  srs_pkg::out_pkt_t              out_r;

  logic [7:0]                     perm_code;
  logic [1:0]                     pcol;
  logic [srs_pkg::ACC_W-1:0]      elem, elem_mag;
  logic                           acc_pos;
  logic [srs_pkg::DET_W-1:0]      acc_mag, mul_sum;
  logic                           rem_ge;
  logic signed [srs_pkg::RES_W-1:0] k_sat, scale;
  logic signed [srs_pkg::RES_W:0] sc_wide;
  logic                           out_free;

  always_comb begin
    perm_code = srs_pkg::PERM_TBL[idx_r];
    pcol      = perm_code[{row_r, 1'b0} +: 2];
    // In the numerator pass one column of the matrix is the right-hand side.
    if (num_phase_r && (pcol == col_r)) begin
      elem = head_data.rhs_sums[row_r];
    end else begin
      elem = head_data.normal_sums[srs_pkg::sym_idx(row_r, pcol)];
    end
    elem_mag = elem[srs_pkg::ACC_W-1] ? (~elem + 1'b1) : elem;
    acc_pos  = !acc_r[srs_pkg::DET_W-1] && (|acc_r);
    acc_mag  = acc_r[srs_pkg::DET_W-1] ? (~acc_r + 1'b1) : acc_r;
    mul_sum  = {prod_r[srs_pkg::DET_W-2:0], 1'b0}
               + (mag_r[srs_pkg::ACC_W-1] ? base_r : '0);
    rem_ge   = (rem_r >= dv_r);
    out_free = !out_valid_r || out_ready;

    // Saturate the rounded quotient magnitude to a signed 32-bit value.
    if (quo_r[srs_pkg::QUO_W-1]) begin
      k_sat = qneg_r ? RES_MIN : RES_MAX;
    end else if (!qneg_r) begin
      k_sat = (|quo_r[32:31]) ? RES_MAX : quo_r[31:0];
    end else if (quo_r[32] || (quo_r[31] && (|quo_r[30:0]))) begin
      k_sat = RES_MIN;
    end else begin
      k_sat = -quo_r[31:0];
    end

    sc_wide = {k_r[0][srs_pkg::RES_W-1], k_r[0]} + ONE_Q;
    scale   = (!sc_wide[srs_pkg::RES_W] && sc_wide[srs_pkg::RES_W-1])
              ? RES_MAX : sc_wide[srs_pkg::RES_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      srs_pkg::ST_IDLE: begin
        if (head_valid) begin
          state_nxt = srs_pkg::ST_TERM;
        end
      end
      srs_pkg::ST_TERM: state_nxt = srs_pkg::ST_LOAD;
      srs_pkg::ST_LOAD: state_nxt = srs_pkg::ST_MUL;
      srs_pkg::ST_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = (row_r == ord_r) ? srs_pkg::ST_ACC : srs_pkg::ST_LOAD;
        end
      end
      srs_pkg::ST_ACC: begin
        state_nxt = (idx_r == srs_pkg::term_last(ord_r)) ? srs_pkg::ST_CHECK
                                                         : srs_pkg::ST_TERM;
      end
      srs_pkg::ST_CHECK: begin
        if (num_phase_r) begin
          state_nxt = srs_pkg::ST_DIV_INIT;
        end else if (!acc_pos) begin
          state_nxt = srs_pkg::ST_FINISH;
        end else begin
          state_nxt = srs_pkg::ST_TERM;
        end
      end
      srs_pkg::ST_DIV_INIT: state_nxt = srs_pkg::ST_DIV;
      srs_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = srs_pkg::ST_STORE;
        end
      end
      srs_pkg::ST_STORE: begin
        state_nxt = (col_r == 2'd3) ? srs_pkg::ST_FINISH : srs_pkg::ST_TERM;
      end
      srs_pkg::ST_FINISH: begin
        if (out_free) begin
          pop       = 1'b1;
          state_nxt = srs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      srs_pkg::ST_IDLE: begin
        num_phase_r <= 1'b0;
        ord_r       <= 2'd0;
        col_r       <= 2'd0;
        acc_r       <= '0;
        idx_r       <= '0;
        sing_r      <= 1'b0;
      end
      srs_pkg::ST_TERM: begin
        prod_r <= srs_pkg::DET_W'(1);
        row_r  <= 2'd0;
        neg_r  <= srs_pkg::perm_odd(perm_code);
      end
      srs_pkg::ST_LOAD: begin
        base_r <= prod_r;
        prod_r <= '0;
        mag_r  <= elem_mag;
        neg_r  <= neg_r ^ elem[srs_pkg::ACC_W-1];
        cnt_r  <= srs_pkg::MCNT_W'(srs_pkg::ACC_W - 1);
      end
      srs_pkg::ST_MUL: begin
        prod_r <= mul_sum;
        mag_r  <= mag_r << 1;
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else if (row_r != ord_r) begin
          row_r <= row_r + 1'b1;
        end
      end
      srs_pkg::ST_ACC: begin
        acc_r <= neg_r ? (acc_r - prod_r) : (acc_r + prod_r);
        idx_r <= idx_r + 1'b1;
      end
      srs_pkg::ST_CHECK: begin
        if (!num_phase_r) begin
          acc_r <= '0;
          idx_r <= '0;
          if (!acc_pos) begin
            // A leading minor that is not positive: identity transform.
            sing_r <= 1'b1;
            for (int i = 0; i < 4; i++) begin
              k_r[i] <= '0;
            end
          end else if (ord_r == 2'd3) begin
            den_r       <= acc_r;
            num_phase_r <= 1'b1;
            col_r       <= 2'd0;
          end else begin
            ord_r <= ord_r + 1'b1;
          end
        end
      end
      srs_pkg::ST_DIV_INIT: begin
        // Rounded ratio: (|num| * 2^17 + den) / (2 * den), floored.
        qneg_r <= acc_r[srs_pkg::DET_W-1];
        rem_r  <= (srs_pkg::DIV_W'(acc_mag) << (srs_pkg::FRAC_BITS + 1))
                  + srs_pkg::DIV_W'(den_r);
        dv_r   <= srs_pkg::DIV_W'(den_r) << srs_pkg::QUO_W;
        quo_r  <= '0;
        cnt_r  <= srs_pkg::MCNT_W'(srs_pkg::QUO_W - 1);
      end
      srs_pkg::ST_DIV: begin
        if (rem_ge) begin
          rem_r <= rem_r - dv_r;
        end
        quo_r <= {quo_r[srs_pkg::QUO_W-2:0], rem_ge};
        dv_r  <= dv_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      srs_pkg::ST_STORE: begin
        k_r[col_r] <= k_sat;
        col_r      <= col_r + 1'b1;
        acc_r      <= '0;
        idx_r      <= '0;
      end
      srs_pkg::ST_FINISH: begin
        if (out_free) begin
          out_r.scale_term    <= scale;
          out_r.rotation_term <= k_r[1];
          out_r.shift_x       <= k_r[2];
          out_r.shift_y       <= k_r[3];
          out_r.singular      <= sing_r;
        end
      end
      default: begin
        num_phase_r <= 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/similarity_registration_solver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// similarity_registration_solver_top: Gauss-Newton similarity solver
// Accumulates the normal equations of a frame of pixel samples and, on the
// last pixel, solves them exactly for the scale, rotation and shift terms.
//
//   Channel   Ports                          Carries
//   input     in_valid, in_ready, in_data    one pixel sample
//   output    out_valid, out_ready, out_data one transform per frame
//
// Pixels are taken one per cycle while in_ready is high and pass through
// the sample, product, factor and saturated-product registers to the sums.
// Solve time is set by the solver's bit-serial 64-bit determinant multiplier.
// The frame queue holds two frames; in_ready drops once two frames are queued
// or on their way in, until the solver frees a slot.
// A stalled output holds its result in the output register; the solver waits.
// Reset is synchronous and clears the sums, the queue and the output.
// ----------------------------------------------------------------------------
module similarity_registration_solver_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srs_pkg::in_pkt_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srs_pkg::out_pkt_t out_data
);

  logic            push_valid;
  srs_pkg::frame_t push_data;
  logic            pop;
  logic            head_valid;
  srs_pkg::frame_t head_data;
  srs_pkg::qstat_t qstat;

  srs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .qstat      (qstat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  srs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .qstat      (qstat)
  );

  srs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/core/srs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_checker: port-level checks of the similarity solver
// Watches the top-level ports and flags reset, result and output slips.
// ----------------------------------------------------------------------------
module srs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input srs_pkg::in_pkt_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input srs_pkg::out_pkt_t out_data
);

  // After reset the block is empty and ready for pixels.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not empty after reset");

  // A singular frame must report the identity transform.
  a_singular_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.scale_term == 32'sd65536 && out_data.rotation_term == 32'sd0 &&
       out_data.shift_x == 32'sd0 && out_data.shift_y == 32'sd0))
    else $error("singular result is not the identity");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind similarity_registration_solver_top srs_checker u_srs_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the similarity registration solver
// Streams frames of pixel samples with random gaps and output stalls. A
// scoreboard keeps its own copy of the normal and right-hand sums, solves each
// frame exactly on wide integers and compares every transform field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  CLK_HALF    = 5;
  localparam int  CYCLE_LIMIT = 120000000;
  localparam int  DRAIN_WAIT  = 200;
  localparam int  QUIET_ITEMS = 100;
  localparam int  WIDE        = 320;
  localparam int  DIVW        = 400;

  typedef enum int {FR_RANDOM, FR_SMALL, FR_EXTREME, FR_ZERO, FR_SATURATE} frame_kind_t;

  class transform_scoreboard;
    logic signed [63:0] norm_acc [10];
    logic signed [63:0] rhs_acc [4];
    srs_pkg::out_pkt_t  pending_xforms [$];
    int                 errors;

    function new();
      clear_sums();
      errors = 0;
    endfunction

    function void clear_sums();
      for (int i = 0; i < 10; i++) norm_acc[i] = '0;
      for (int i = 0; i < 4; i++) rhs_acc[i] = '0;
    endfunction

    function logic signed [63:0] mul_sat(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] w;
      w = 128'(a) * 128'(b);
      if (w > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (w < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return w[63:0];
    endfunction

    function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] w;
      w = 65'(a) + 65'(b);
      if (w > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (w < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return w[63:0];
    endfunction

    // Full permutation expansion of a 4x4 determinant.
    function logic signed [WIDE-1:0] det4(logic signed [63:0] m [4][4]);
      logic signed [WIDE-1:0] acc;
      logic signed [WIDE-1:0] term;
      int p [4];
      int inv;
      acc = '0;
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++)
          for (int c = 0; c < 4; c++)
            for (int d = 0; d < 4; d++) begin
              if (a == b || a == c || a == d || b == c || b == d || c == d) continue;
              p[0] = a; p[1] = b; p[2] = c; p[3] = d;
              inv = 0;
              for (int i = 0; i < 3; i++)
                for (int j = i + 1; j < 4; j++)
                  if (p[i] > p[j]) inv++;
              term = WIDE'(m[0][a]) * WIDE'(m[1][b]) * WIDE'(m[2][c]) * WIDE'(m[3][d]);
              if (inv % 2) acc = acc - term;
              else acc = acc + term;
            end
      return acc;
    endfunction

    // Rounds num * 2^16 / den half away from zero, den positive.
    function logic signed [31:0] q16_quot(logic signed [WIDE-1:0] num,
                                          logic signed [WIDE-1:0] den);
      logic [DIVW-1:0] a;
      logic [DIVW-1:0] q;
      logic            neg;
      neg = num < 0;
      a = DIVW'(neg ? -num : num);
      a = (a << 17) + DIVW'(den);
      q = a / (DIVW'(den) << 1);
      if (!neg) return (q > DIVW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
      if (q > DIVW'(33'h0_8000_0000)) return 32'sh8000_0000;
      return -q[31:0];
    endfunction

    function srs_pkg::out_pkt_t solve_frame();
      logic signed [63:0]     m [4][4];
      logic signed [63:0]     mc [4][4];
      logic signed [WIDE-1:0] det;
      logic signed [WIDE-1:0] kv [4];
      logic signed [32:0]     sc;
      srs_pkg::out_pkt_t      r;
      int                     n;
      bit                     pd;
      n = 0;
      for (int i = 0; i < 4; i++)
        for (int j = i; j < 4; j++) begin
          m[i][j] = norm_acc[n];
          m[j][i] = norm_acc[n];
          n++;
        end
      pd = 1;
      for (int ord = 1; ord <= 4; ord++) begin
        mc = m;
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++)
            if (i >= ord || j >= ord) mc[i][j] = (i == j) ? 64'sd1 : 64'sd0;
        det = det4(mc);
        if (det <= 0) pd = 0;
      end
      for (int i = 0; i < 4; i++) kv[i] = '0;
      if (pd) begin
        for (int i = 0; i < 4; i++) begin
          mc = m;
          for (int j = 0; j < 4; j++) mc[j][i] = rhs_acc[j];
          kv[i] = q16_quot(det4(mc), det);
        end
      end
      sc = 33'(signed'(kv[0][31:0])) + 33'sd65536;
      if (sc > 33'sh0_7FFF_FFFF) sc = 33'sh0_7FFF_FFFF;
      r.scale_term    = sc[31:0];
      r.rotation_term = kv[1][31:0];
      r.shift_x       = kv[2][31:0];
      r.shift_y       = kv[3][31:0];
      r.singular      = !pd;
      return r;
    endfunction

    function void note_pixel(srs_pkg::in_pkt_t px);
      logic signed [63:0] x, y, gx, gy, nd;
      logic signed [63:0] f [4];
      int n;
      x  = 64'(px.col_coord);
      y  = 64'(px.row_coord);
      gx = 64'(px.grad_x);
      gy = 64'(px.grad_y);
      nd = -64'(px.intensity_diff);
      f[0] = x * gx + y * gy;
      f[1] = y * gx - x * gy;
      f[2] = gx;
      f[3] = gy;
      n = 0;
      for (int i = 0; i < 4; i++) begin
        for (int j = i; j < 4; j++) begin
          norm_acc[n] = add_sat(norm_acc[n], mul_sat(f[i], f[j]));
          n++;
        end
        rhs_acc[i] = add_sat(rhs_acc[i], mul_sat(nd, f[i]));
      end
      if (px.last_pixel) begin
        pending_xforms.push_back(solve_frame());
        clear_sums();
      end
    endfunction

    function void check_xform(srs_pkg::out_pkt_t got);
      srs_pkg::out_pkt_t want;
      if (pending_xforms.size() == 0) begin
        $error("transform with none expected: %h", got);
        errors++;
        return;
      end
      want = pending_xforms.pop_front();
      if (got.scale_term !== want.scale_term) begin
        $error("scale_term expected %0d actual %0d", want.scale_term, got.scale_term);
        errors++;
      end
      if (got.rotation_term !== want.rotation_term) begin
        $error("rotation_term expected %0d actual %0d", want.rotation_term,
               got.rotation_term);
        errors++;
      end
      if (got.shift_x !== want.shift_x) begin
        $error("shift_x expected %0d actual %0d", want.shift_x, got.shift_x);
        errors++;
      end
      if (got.shift_y !== want.shift_y) begin
        $error("shift_y expected %0d actual %0d", want.shift_y, got.shift_y);
        errors++;
      end
      if (got.singular !== want.singular) begin
        $error("singular expected %0d actual %0d", want.singular, got.singular);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  srs_pkg::in_pkt_t  in_data;
  logic              out_valid;
  logic              out_ready;
  srs_pkg::out_pkt_t out_data;

  transform_scoreboard sb;
  bit  quiet;
  int  stall_left;
  int  cycles;
  int  items_left;

  similarity_registration_solver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output stalls come in bursts; none near the end of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Outputs are sampled mid-cycle, where they are settled for the next edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_xform(out_data);
  end

  task automatic send_pixel(srs_pkg::in_pkt_t px);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_pixel(px);
    items_left--;
    if (items_left < QUIET_ITEMS) quiet = 1;
  endtask

  task automatic send_frame(int len, frame_kind_t kind);
    srs_pkg::in_pkt_t px;
    logic [95:0]      rnd;
    for (int i = 0; i < len; i++) begin
      rnd = {$urandom, $urandom, $urandom};
      px  = rnd[$bits(srs_pkg::in_pkt_t)-1:0];
      case (kind)
        FR_SMALL: begin
          px.col_coord      = srs_pkg::COORD_BITS'($urandom_range(0, 64) - 32);
          px.row_coord      = srs_pkg::COORD_BITS'($urandom_range(0, 64) - 32);
          px.grad_x         = srs_pkg::SAMPLE_BITS'($urandom_range(0, 512) - 256);
          px.grad_y         = srs_pkg::SAMPLE_BITS'($urandom_range(0, 512) - 256);
          px.intensity_diff = srs_pkg::SAMPLE_BITS'($urandom_range(0, 128) - 64);
        end
        FR_EXTREME: begin
          px.col_coord      = i[0] ? 12'sh7FF : 12'sh800;
          px.row_coord      = i[1] ? 12'sh7FF : 12'sh800;
          px.grad_x         = i[2] ? 16'sh7FFF : 16'sh8000;
          px.grad_y         = (i[0] ^ i[2]) ? 16'sh8000 : 16'sh7FFF;
          px.intensity_diff = i[1] ? 16'sh7FFF : 16'sh8000;
        end
        FR_ZERO: px = '0;
        FR_SATURATE: begin
          // Extremes push the sums into saturation; some random samples keep
          // the matrix from being rank one.
          if (i % 4 != 0) begin
            px.col_coord      = 12'sh800;
            px.row_coord      = 12'sh800;
            px.grad_x         = 16'sh8000;
            px.grad_y         = 16'sh8000;
            px.intensity_diff = i[0] ? 16'sh8000 : 16'sh7FFF;
          end
        end
        default: ;
      endcase
      px.last_pixel = (i == len - 1);
      send_pixel(px);
    end
  endtask

  initial begin
    sb         = new();
    quiet      = 0;
    items_left = 900;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero frame, a lone sample, corner values, a normal frame.
    send_frame(1, FR_ZERO);
    send_frame(1, FR_EXTREME);
    send_frame(3, FR_SMALL);
    send_frame(8, FR_EXTREME);
    send_frame(8, FR_SMALL);

    while (items_left > 0) begin
      case ($urandom_range(0, 9))
        0:       send_frame($urandom_range(1, 3), FR_RANDOM);
        1, 2, 3: send_frame($urandom_range(4, 30), FR_SMALL);
        4:       send_frame($urandom_range(0, 1) ? 8 : 16, FR_EXTREME);
        5:       send_frame((items_left > 400) ? 140 : 6, FR_SATURATE);
        default: send_frame($urandom_range(4, 30), FR_RANDOM);
      endcase
    end
    in_valid <= 1'b0;

    while (sb.pending_xforms.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_xforms.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/srs_pkg.sv
rtl/core/srs_front.sv
rtl/core/srs_queue.sv
rtl/core/srs_back.sv
rtl/core/similarity_registration_solver_top.sv
rtl/core/srs_checker.sv
test/testbench.sv
